/* design/big_endian_width_converter_core_defines.svh */
// Assertion macros used by the checker of the width converter.
`ifndef BIG_ENDIAN_WIDTH_CONVERTER_CORE_DEFINES_SVH
`define BIG_ENDIAN_WIDTH_CONVERTER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BEWC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BEWC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/bewc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bewc_pkg;

   localparam int DATA_W     = 64;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int SIZE_W     = 2;

   // Register indexes, taken from bit 2 of the byte address.
   localparam logic REG_SRC_SIZE = 1'b0;
   localparam logic REG_DST_SIZE = 1'b1;

   // Size codes (log2 of the width in bytes).
   localparam logic [SIZE_W-1:0] SIZE_1B = 2'd0;
   localparam logic [SIZE_W-1:0] SIZE_2B = 2'd1;
   localparam logic [SIZE_W-1:0] SIZE_4B = 2'd2;
   localparam logic [SIZE_W-1:0] SIZE_8B = 2'd3;

   // Mask that keeps the low bytes of a value of the given size code.
   function automatic logic [DATA_W-1:0] size_mask(input logic [SIZE_W-1:0] size_log2);
      logic [DATA_W-1:0] mask;
      case (size_log2)
         SIZE_1B: mask = 64'h0000_0000_0000_00FF;
         SIZE_2B: mask = 64'h0000_0000_0000_FFFF;
         SIZE_4B: mask = 64'h0000_0000_FFFF_FFFF;
         default: mask = {DATA_W{1'b1}};
      endcase
      return mask;
   endfunction

   // Width in bytes for a size code (1, 2, 4 or 8).
   function automatic logic [3:0] size_bytes(input logic [SIZE_W-1:0] size_log2);
      return 4'(4'd1 << size_log2);
   endfunction

endpackage

`default_nettype wire

/* design/big_endian_width_converter_core.sv */
// Big-endian stream width converter.
// Items of 1, 2, 4 or 8 bytes arrive on the req_ stream (tdata holds the item in its low
// bytes, tlast marks the end of the stream) and leave as words of 1, 2, 4 or 8 bytes on
// the rsp_ stream, most significant part first. Both sizes are set through the csr_ port
// and must only be written while the block is idle; a write drops any partly gathered word.
// An accepted item is held in an input register; its words then move from there into the
// output register, which drives the rsp_ stream, whenever that register is free.
// Passing through and upsizing take one item per cycle unless the receiver stalls.
// Downsizing hands out each item as src/dst words, one word per cycle while not stalled.
// Upsizing gathers items in a staging register and sends a word when it is full or when
// the last item arrives, zero-padded in its low bytes and marked with tlast.
// A stalled receiver holds the output register; the input register still takes an item
// when the one it holds can move on, so one transfer can wait on each side.
// A synchronous reset empties both registers, clears the staging word and sets both
// sizes to one byte.
`timescale 1ns / 1ps
`default_nettype none

module big_endian_width_converter_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Input stream
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [bewc_pkg::DATA_W-1:0]      req_tdata,   // [63:0] item_value
   input  wire logic                             req_tlast,   // last_item
   // Result stream
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [bewc_pkg::DATA_W-1:0]           rsp_tdata,   // [63:0] out_word
   output logic                                  rsp_tlast,   // last_word
   // Configuration port
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [bewc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [bewc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [bewc_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   import bewc_pkg::*;

   // Configuration registers.
   logic [SIZE_W-1:0] src_size_ff, src_size_in;
   logic [SIZE_W-1:0] dst_size_ff, dst_size_in;

   // Input register: the item being worked on.
   logic              hold_valid_ff, hold_valid_in;
   logic [DATA_W-1:0] hold_item_ff, hold_item_in;
   logic              hold_last_ff, hold_last_in;
   logic [2:0]        hold_shift_ff, hold_shift_in;   // byte offset of the next piece

   // Staging word for upsizing and the number of bytes already in it.
   logic [DATA_W-1:0] staging_ff, staging_in;
   logic [2:0]        fill_ff, fill_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              csr_write;
   logic [3:0]        src_bytes;
   logic [3:0]        dst_bytes;
   logic [DATA_W-1:0] dst_mask;
   logic              mode_down;
   logic              mode_up;
   logic [3:0]        used_bytes;
   logic [2:0]        gap_bytes;
   logic [DATA_W-1:0] staging_next;
   logic              step_emit;
   logic              step_final;
   logic [DATA_W-1:0] step_word;
   logic              step_last;
   logic              out_free;
   logic              advance;
   logic              step_done;
   logic              req_accept;

   // A transfer on the configuration port completes in its access cycle.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      csr_prdata = '0;
      case (csr_paddr[2])
         REG_SRC_SIZE: csr_prdata = CSR_DATA_W'(src_size_ff);
         REG_DST_SIZE: csr_prdata = CSR_DATA_W'(dst_size_ff);
         default:      csr_prdata = '0;
      endcase
   end

   always_comb begin
      src_size_in = src_size_ff;
      dst_size_in = dst_size_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            REG_SRC_SIZE: src_size_in = csr_pwdata[SIZE_W-1:0];
            REG_DST_SIZE: dst_size_in = csr_pwdata[SIZE_W-1:0];
            default:      src_size_in = src_size_ff;
         endcase
      end
   end

   assign src_bytes = size_bytes(src_size_ff);
   assign dst_bytes = size_bytes(dst_size_ff);
   assign dst_mask  = size_mask(dst_size_ff);
   assign mode_down = src_size_ff > dst_size_ff;
   assign mode_up   = src_size_ff < dst_size_ff;

   // Upsizing: the held item goes just below the bytes already gathered.
   assign used_bytes   = 4'({1'b0, fill_ff}) + src_bytes;
   assign gap_bytes    = 3'(dst_bytes - used_bytes);
   assign staging_next = staging_ff | (hold_item_ff << {gap_bytes, 3'b000});

   // One step of the held item: which word it yields and whether the item is done.
   always_comb begin
      step_emit  = 1'b1;
      step_final = 1'b1;
      step_word  = hold_item_ff;
      step_last  = hold_last_ff;
      if (mode_down) begin
         step_word  = (hold_item_ff >> {hold_shift_ff, 3'b000}) & dst_mask;
         step_final = hold_shift_ff == 3'd0;
         step_last  = hold_last_ff && step_final;
      end else if (mode_up) begin
         step_word = staging_next & dst_mask;
         step_emit = (used_bytes == dst_bytes) || hold_last_ff;
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = hold_valid_ff && (!step_emit || out_free);
   assign step_done  = advance && step_final;
   assign req_tready = !hold_valid_ff || step_done;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_item_in  = hold_item_ff;
      hold_last_in  = hold_last_ff;
      hold_shift_in = hold_shift_ff;
      if (req_accept) begin
         hold_valid_in = 1'b1;
         hold_item_in  = req_tdata & size_mask(src_size_ff);
         hold_last_in  = req_tlast;
         // Offset of the most significant piece; only used when downsizing.
         hold_shift_in = 3'(src_bytes - dst_bytes);
      end else if (step_done) begin
         hold_valid_in = 1'b0;
      end else if (advance) begin
         hold_shift_in = 3'(hold_shift_ff - 3'(dst_bytes));
      end
   end

   always_comb begin
      staging_in = staging_ff;
      fill_in    = fill_ff;
      if (csr_write) begin
         staging_in = '0;
         fill_in    = '0;
      end else if (advance && mode_up) begin
         if (step_emit) begin
            staging_in = '0;
            fill_in    = '0;
         end else begin
            staging_in = staging_next;
            fill_in    = used_bytes[2:0];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (advance && step_emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = step_word;
         rsp_last_in  = step_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_size_ff   <= '0;
         dst_size_ff   <= '0;
         hold_valid_ff <= 1'b0;
         staging_ff    <= '0;
         fill_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         src_size_ff   <= src_size_in;
         dst_size_ff   <= dst_size_in;
         hold_valid_ff <= hold_valid_in;
         staging_ff    <= staging_in;
         fill_ff       <= fill_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_item_ff  <= hold_item_in;
      hold_last_ff  <= hold_last_in;
      hold_shift_ff <= hold_shift_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

/* design/bewc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "big_endian_width_converter_core_defines.svh"

module bewc_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic [bewc_pkg::DATA_W-1:0]      req_tdata,
   input wire logic                             req_tlast,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [bewc_pkg::DATA_W-1:0]      rsp_tdata,
   input wire logic                             rsp_tlast,
   input wire logic                             csr_psel,
   input wire logic                             csr_penable,
   input wire logic                             csr_pwrite,
   input wire logic [bewc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input wire logic [bewc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   input wire logic [bewc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   input wire logic                             csr_pready
);

   // A stalled result transfer keeps its word and marker.
   `BEWC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "result changed while stalled")

   // When the input is blocked with an empty output, the held item must produce a word.
   `BEWC_ASSERT_NEXT(a_progress, !req_tready && !rsp_tvalid, rsp_tvalid, "blocked input did not produce a word")

   // A blocked input stays blocked while the output remains stalled.
   `BEWC_ASSERT_NEXT(a_block_kept, rsp_tvalid && !rsp_tready && !req_tready, !req_tready || rsp_tready, "input freed while output still stalled")

   // The configuration port never inserts wait states.
   `BEWC_ASSERT_SAME(a_csr_ready, csr_psel && csr_penable, csr_pready, "configuration transfer stalled")

endmodule

bind big_endian_width_converter_core bewc_checker u_bewc_checker (.*);

`default_nettype wire
